@@ sv/hcbp_pkg.sv @@
package hcbp_pkg;

  localparam int BYTE_W    = 8;
  localparam int SYM_W     = 8;
  localparam int PWORD_W   = 16;
  localparam int CMD_W     = 2;
  localparam int IN_DATA_W = SYM_W + PWORD_W;

  localparam logic [SYM_W-1:0] TERM_SYMBOL = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_END    = 2'd2
  } hcbp_cmd_t;

  typedef struct packed {
    logic vld;
    logic flush;
  } hcbp_ctl_t;

endpackage

@@ sv/hcbp_packer.sv @@
module hcbp_packer #(
  parameter int PATH_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hcbp_pkg::hcbp_ctl_t           ctl,
  input  logic [PATH_WIDTH-1:0]         code,
  input  logic [$clog2(PATH_WIDTH)-1:0] len,
  output logic                          load,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hcbp_pkg::BYTE_W-1:0]   out_tdata,  // out_byte
  output logic                          out_tlast   // last_of_run
);
  import hcbp_pkg::*;

  localparam int BW = PATH_WIDTH + BYTE_W - 2;
  localparam int CW = $clog2(BW + 1);

  logic [BW-1:0]     bits_r, bits_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt, cnt_after;
  logic              flush_r, flush_nxt, flush_after;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt, byte_val;
  logic              ol_r, ol_nxt;
  logic              full, part, slot, emit, idle;

  always_comb begin
    full        = cnt_r >= CW'(BYTE_W);
    part        = !full && flush_r && (cnt_r != '0);
    slot        = !ov_r || out_tready;
    emit        = (full || part) && slot;
    cnt_after   = cnt_r;
    if (emit) begin
      cnt_after = full ? cnt_r - CW'(BYTE_W) : '0;
    end
    flush_after = flush_r && (cnt_after != '0);
    idle        = (cnt_after < CW'(BYTE_W)) && !flush_after;
    load        = ctl.vld && idle;

    if (full) begin
      byte_val = BYTE_W'(bits_r >> (cnt_r - CW'(BYTE_W)));
    end else begin
      byte_val = BYTE_W'(bits_r << (CW'(BYTE_W) - cnt_r));
    end

    bits_nxt  = bits_r;
    cnt_nxt   = cnt_after;
    flush_nxt = flush_after;
    if (load) begin
      bits_nxt  = (bits_r << len) | BW'(code);
      cnt_nxt   = cnt_after + CW'(len);
      flush_nxt = ctl.flush;
    end

    ov_nxt = ov_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    if (emit) begin
      ov_nxt = 1'b1;
      ob_nxt = byte_val;
      ol_nxt = idle;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      flush_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tlast  = ol_r;

endmodule

@@ sv/huffman_code_bit_packer.sv @@
// Huffman code bit packer.
// Input requests carry a command in in_tuser: write stores a path word for one
// symbol, encode packs that symbol's code, end packs the code of symbol 0 and
// then flushes the partial byte left-aligned with zero padding.
// Output requests carry one packed byte, first code bit in bit 7; out_tlast
// marks the last byte caused by one input request.
// The first byte of an item passes the code table read, the code length decode
// and the bit merge registers, then the output register.
// Throughput: one item per cycle while each item yields at most one byte and
// the receiver takes every byte; an item yielding more bytes holds the input
// back, since the single output register drains one byte per cycle.
// Reset clears the per-entry valid bits, so every symbol reads as an empty
// code at once, and clears the pending bit count; there is no clearing pass.
// A stalled receiver holds out_tdata/out_tlast; the pipeline keeps taking
// input until its stage registers fill, then drops in_tready.
module huffman_code_bit_packer #(
  parameter int SYMBOL_COUNT = 256,
  parameter int PATH_WIDTH   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hcbp_pkg::IN_DATA_W-1:0]   in_tdata,   // symbol, path_word
  input  logic [hcbp_pkg::CMD_W-1:0]       in_tuser,   // command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hcbp_pkg::BYTE_W-1:0]      out_tdata,  // out_byte
  output logic                             out_tlast   // last_of_run
);
  import hcbp_pkg::*;

  localparam int AW = $clog2(SYMBOL_COUNT);
  localparam int LW = $clog2(PATH_WIDTH);

  logic [PATH_WIDTH-1:0]   mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_r;

  hcbp_cmd_t         cmd;
  logic [SYM_W-1:0]  sym, rd_sym;
  logic [PWORD_W-1:0] pw;
  logic              accept, is_wr, is_rd, is_end, wr_inr, rd_inr;

  logic [PATH_WIDTH-1:0] rd_data_r;
  logic                  rd_ok_r;
  logic                  s1_v_r, s1_v_nxt, s1_end_r, s1_adv;
  logic [PATH_WIDTH-1:0] word, s1_code;
  logic [LW-1:0]         s1_len;

  logic                  s2_v_r, s2_v_nxt, s2_end_r, s2_free;
  logic [PATH_WIDTH-1:0] s2_code_r;
  logic [LW-1:0]         s2_len_r;
  logic                  pk_load;
  hcbp_ctl_t             pk_ctl;

  assign sym    = in_tdata[SYM_W-1:0];
  assign pw     = in_tdata[IN_DATA_W-1:SYM_W];
  assign cmd    = hcbp_cmd_t'(in_tuser);
  assign accept = in_tvalid && in_tready;

  always_comb begin
    is_wr  = 1'b0;
    is_rd  = 1'b0;
    is_end = 1'b0;
    case (cmd)
      CMD_WRITE:  is_wr = 1'b1;
      CMD_ENCODE: is_rd = 1'b1;
      CMD_END: begin
        is_rd  = 1'b1;
        is_end = 1'b1;
      end
      default: ;
    endcase
    rd_sym = is_end ? TERM_SYMBOL : sym;
    wr_inr = {1'b0, sym} < (SYM_W + 1)'(SYMBOL_COUNT);
    rd_inr = {1'b0, rd_sym} < (SYM_W + 1)'(SYMBOL_COUNT);
  end

  always_ff @(posedge clk) begin
    if (accept && is_wr && wr_inr) begin
      mem[sym[AW-1:0]] <= PATH_WIDTH'(pw);
    end
    if (accept && is_rd) begin
      rd_data_r <= mem[rd_sym[AW-1:0]];
      rd_ok_r   <= vld_r[rd_sym[AW-1:0]] && rd_inr;
      s1_end_r  <= is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (accept && is_wr && wr_inr) begin
      vld_r[sym[AW-1:0]] <= 1'b1;
    end
  end

  assign s2_free   = !s2_v_r || pk_load;
  assign s1_adv    = s1_v_r && s2_free;
  assign in_tready = !s1_v_r || s2_free;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept && is_rd) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_free ? s1_v_r : s2_v_r;
  end

  always_comb begin
    word   = rd_ok_r ? rd_data_r : PATH_WIDTH'(1);
    s1_len = '0;
    for (int k = 0; k < PATH_WIDTH; k++) begin
      if (word[k]) begin
        s1_len = LW'(k);
      end
    end
    s1_code         = word;
    s1_code[s1_len] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_code_r <= s1_code;
      s2_len_r  <= s1_len;
      s2_end_r  <= s1_end_r;
    end
  end

  assign pk_ctl.vld   = s2_v_r;
  assign pk_ctl.flush = s2_end_r;

  hcbp_packer #(
    .PATH_WIDTH (PATH_WIDTH)
  ) u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pk_ctl),
    .code       (s2_code_r),
    .len        (s2_len_r),
    .load       (pk_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ sv/hcbp_checker.sv @@
module hcbp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [hcbp_pkg::IN_DATA_W-1:0] in_tdata,
  input logic [hcbp_pkg::CMD_W-1:0]     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [hcbp_pkg::BYTE_W-1:0]    out_tdata,
  input logic                           out_tlast
);
  import hcbp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output request changed while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output valid or input stalled after reset");

  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("byte run broken before its last byte");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
